// ----- sv/bsfd_pkg.sv -----
// Shared types and constants for the byte-stuffed frame deframer.
// No dependencies; used by bsfd_step and byte_stuffed_frame_deframer_top.
package bsfd_pkg;

  typedef enum logic [1:0] {
    MODE_HUNT     = 2'd0,
    MODE_IN_FRAME = 2'd1,
    MODE_ESCAPED  = 2'd2
  } mode_t;

  localparam logic KIND_DATA      = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  localparam logic [1:0] CFG_FLAG_BYTE   = 2'd0;
  localparam logic [1:0] CFG_ESCAPE_BYTE = 2'd1;
  localparam logic [1:0] CFG_ESCAPE_MASK = 2'd2;
  localparam logic [1:0] CFG_MAX_LENGTH  = 2'd3;

  localparam logic [7:0] FLAG_RESET   = 8'd126;
  localparam logic [7:0] ESCAPE_RESET = 8'd125;
  localparam logic [7:0] MASK_RESET   = 8'd32;
  localparam logic [8:0] MAXLEN_RESET = 9'd256;

  typedef struct packed {
    logic [7:0] flag_byte;
    logic [7:0] escape_byte;
    logic [7:0] escape_mask;
    logic [8:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] position;
    logic [1:0] buffer_slot;
    logic [7:0] frame_length;
  } result_t;

endpackage

// ----- sv/byte_stuffed_frame_deframer_top.sv -----
// Top level of the byte-stuffed frame deframer: input register, state, result register.
// Depends on bsfd_pkg and bsfd_step.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_ready  rx_byte, datagram_start
//   out      source     out_valid/out_ready  kind, data_byte, position, buffer_slot,
//                                            frame_length
//   cfg      sink       cfg_we (no wait)     cfg_index, cfg_data
//
// One beat per cycle sustained unless the result stalls; a beat passes the input register
// and then the result register. The input register feeds the per-byte logic, which
// updates the state and the result register in the same cycle. Reset sets the config
// registers to defaults, clears valid flags, starts in hunt mode, slot zero. A stalled
// result holds the input register; the input side stops only when both stages are full.
module byte_stuffed_frame_deframer_top #(
  parameter int NUM_BUFFERS     = 4,
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       datagram_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] data_byte,
  output logic [7:0] position,
  output logic [1:0] buffer_slot,
  output logic [7:0] frame_length,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int SLOT_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

  bsfd_pkg::cfg_t    cfg;
  bsfd_pkg::mode_t   mode;
  bsfd_pkg::mode_t   mode_next;
  logic [CNT_W-1:0]  byte_count;
  logic [CNT_W-1:0]  byte_count_next;
  logic [SLOT_W-1:0] slot_index;
  logic [SLOT_W-1:0] slot_index_next;
  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_start;
  logic              advance;
  logic              res_valid;
  bsfd_pkg::result_t res;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag_byte   <= bsfd_pkg::FLAG_RESET;
      cfg.escape_byte <= bsfd_pkg::ESCAPE_RESET;
      cfg.escape_mask <= bsfd_pkg::MASK_RESET;
      cfg.max_length  <= bsfd_pkg::MAXLEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bsfd_pkg::CFG_FLAG_BYTE:   cfg.flag_byte   <= cfg_data[7:0];
        bsfd_pkg::CFG_ESCAPE_BYTE: cfg.escape_byte <= cfg_data[7:0];
        bsfd_pkg::CFG_ESCAPE_MASK: cfg.escape_mask <= cfg_data[7:0];
        bsfd_pkg::CFG_MAX_LENGTH:  cfg.max_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte  <= rx_byte;
      s1_start <= datagram_start;
    end
  end

  bsfd_step #(
    .NUM_BUFFERS     (NUM_BUFFERS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .CNT_W           (CNT_W),
    .SLOT_W          (SLOT_W)
  ) u_step (
    .cfg             (cfg),
    .rx_byte         (s1_byte),
    .datagram_start  (s1_start),
    .mode            (mode),
    .byte_count      (byte_count),
    .slot_index      (slot_index),
    .mode_next       (mode_next),
    .byte_count_next (byte_count_next),
    .slot_index_next (slot_index_next),
    .res_valid       (res_valid),
    .res             (res)
  );

  // deframer state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= bsfd_pkg::MODE_HUNT;
      byte_count <= '0;
      slot_index <= '0;
    end else if (s1_valid && advance) begin
      mode       <= mode_next;
      byte_count <= byte_count_next;
      slot_index <= slot_index_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && res_valid) begin
      kind         <= res.kind;
      data_byte    <= res.data_byte;
      position     <= res.position;
      buffer_slot  <= res.buffer_slot;
      frame_length <= res.frame_length;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(MAX_FRAME_BYTES) >= byte_count)
    else $error("byte count beyond frame limit");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    (SLOT_W + 1)'(slot_index) < (SLOT_W + 1)'(NUM_BUFFERS))
    else $error("slot index out of range");

  a_frame_end_rearm: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid && res_valid && res.kind == bsfd_pkg::KIND_FRAME_END) |=>
    (mode == bsfd_pkg::MODE_HUNT && byte_count == '0))
    else $error("frame end did not return to hunt");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_byte) && $stable(s1_start)))
    else $error("input stage lost a beat during stall");
`endif

endmodule

// ----- sv/bsfd_step.sv -----
// Per-byte deframing logic: next mode, byte count and slot, plus the result beat.
// Depends on bsfd_pkg.
module bsfd_step #(
  parameter int NUM_BUFFERS     = 4,
  parameter int MAX_FRAME_BYTES = 256,
  parameter int CNT_W           = 9,
  parameter int SLOT_W          = 2
) (
  input  bsfd_pkg::cfg_t    cfg,
  input  logic [7:0]        rx_byte,
  input  logic              datagram_start,
  input  bsfd_pkg::mode_t   mode,
  input  logic [CNT_W-1:0]  byte_count,
  input  logic [SLOT_W-1:0] slot_index,
  output bsfd_pkg::mode_t   mode_next,
  output logic [CNT_W-1:0]  byte_count_next,
  output logic [SLOT_W-1:0] slot_index_next,
  output logic              res_valid,
  output bsfd_pkg::result_t res
);

  localparam int LIM_W  = (CNT_W > 9) ? CNT_W : 9;
  localparam int SLOT_X = (SLOT_W > 2) ? SLOT_W : 2;
  localparam logic [LIM_W-1:0]  MAX_LIM   = LIM_W'(MAX_FRAME_BYTES);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_BUFFERS - 1);

  logic [LIM_W-1:0]  max_ext;
  logic [LIM_W-1:0]  limit;
  logic [LIM_W-1:0]  cnt_start_ext;
  logic [LIM_W-1:0]  cnt_ext;
  logic [SLOT_X-1:0] slot_ext;
  logic [CNT_W-1:0]  cnt_start;
  logic [CNT_W-1:0]  cnt_eff;
  logic [CNT_W-1:0]  cnt_inc;
  logic [SLOT_W-1:0] slot_adv;
  bsfd_pkg::mode_t   mode_start;
  bsfd_pkg::mode_t   mode_eff;
  logic              overrun;
  logic              is_flag;
  logic              is_escape;

  // datagram start, then overrun check, both before the byte is handled
  always_comb begin
    max_ext       = LIM_W'(cfg.max_length);
    limit         = (max_ext < MAX_LIM) ? max_ext : MAX_LIM;
    mode_start    = datagram_start ? bsfd_pkg::MODE_HUNT : mode;
    cnt_start     = datagram_start ? '0 : byte_count;
    cnt_start_ext = LIM_W'(cnt_start);
    overrun       = (cnt_start_ext >= limit);
    mode_eff      = overrun ? bsfd_pkg::MODE_HUNT : mode_start;
    cnt_eff       = overrun ? '0 : cnt_start;
    cnt_ext       = LIM_W'(cnt_eff);
    cnt_inc       = cnt_eff + CNT_W'(1);
    slot_ext      = SLOT_X'(slot_index);
    slot_adv      = (slot_index == SLOT_LAST) ? '0 : slot_index + SLOT_W'(1);
    is_flag       = (rx_byte == cfg.flag_byte);
    is_escape     = (rx_byte == cfg.escape_byte);
  end

  // next state
  always_comb begin
    mode_next       = mode_eff;
    byte_count_next = cnt_eff;
    slot_index_next = slot_index;
    case (mode_eff)
      bsfd_pkg::MODE_ESCAPED: begin
        mode_next       = bsfd_pkg::MODE_IN_FRAME;
        byte_count_next = cnt_inc;
      end
      bsfd_pkg::MODE_IN_FRAME: begin
        if (is_escape) begin
          mode_next = bsfd_pkg::MODE_ESCAPED;
        end else if (is_flag) begin
          if (cnt_eff != '0) begin
            mode_next       = bsfd_pkg::MODE_HUNT;
            byte_count_next = '0;
            slot_index_next = slot_adv;
          end
        end else begin
          byte_count_next = cnt_inc;
        end
      end
      default: begin
        mode_next = bsfd_pkg::MODE_HUNT;
        if (is_flag) begin
          mode_next       = bsfd_pkg::MODE_IN_FRAME;
          byte_count_next = '0;
        end
      end
    endcase
  end

  // result beat
  always_comb begin
    res_valid        = 1'b0;
    res.kind         = bsfd_pkg::KIND_DATA;
    res.data_byte    = '0;
    res.position     = '0;
    res.buffer_slot  = slot_ext[1:0];
    res.frame_length = '0;
    case (mode_eff)
      bsfd_pkg::MODE_ESCAPED: begin
        res_valid     = 1'b1;
        res.data_byte = rx_byte ^ cfg.escape_mask;
        res.position  = cnt_ext[7:0];
      end
      bsfd_pkg::MODE_IN_FRAME: begin
        if (!is_escape) begin
          if (is_flag) begin
            if (cnt_eff != '0) begin
              res_valid        = 1'b1;
              res.kind         = bsfd_pkg::KIND_FRAME_END;
              res.frame_length = cnt_ext[7:0];
            end
          end else begin
            res_valid     = 1'b1;
            res.data_byte = rx_byte;
            res.position  = cnt_ext[7:0];
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

endmodule
